// ===== design/ial_pkg.sv =====
// shared codes and controller/datapath interface types for the indexed array list
`default_nettype none

package ial_pkg;

    // command codes
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [2:0] CMD_POP_BACK   = 3'd1;
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd2;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [2:0] CMD_INSERT     = 3'd4;
    localparam logic [2:0] CMD_REMOVE     = 3'd5;
    localparam logic [2:0] CMD_READ       = 3'd6;
    localparam logic [2:0] CMD_WRITE      = 3'd7;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADIDX = 2'd3;

    localparam int CMD_W = 3;
    localparam int POS_W = 5;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture the command fields
        logic setup;     // arm the shift pointer and move count
        logic step;      // one shift step
        logic read_pos;  // read the entry at the target position
        logic place;     // write the command word at the target position
        logic commit;    // update the count and load the result registers
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              ins;        // push_back, push_front, insert
        logic              rem;        // pop_front, remove
        logic              pop_back;
        logic              rd;
        logic              wr;
        logic              shift_done;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== design/ial_datapath.sv =====
// list datapath: entry memory, count, shift pointer and result registers
`default_nettype none

module ial_datapath #(
    parameter int CAPACITY = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire ial_pkg::t_dp_cmd            i_cmd,
    output ial_pkg::t_dp_stat                o_stat,
    input  wire logic [ial_pkg::CMD_W-1:0]   i_command,
    input  wire logic [ial_pkg::POS_W-1:0]   i_position,
    input  wire logic [ial_pkg::DATA_W-1:0]  i_value,
    output logic signed [ial_pkg::DATA_W-1:0] o_read_data,
    output logic [ial_pkg::POS_W-1:0]        o_count,
    output logic                             o_is_empty,
    output logic [ial_pkg::STAT_W-1:0]       o_status
);
    import ial_pkg::*;

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic [DATA_W-1:0] r_mem [CAPACITY];
    logic [DATA_W-1:0] r_rdata;

    logic [CMD_W-1:0]  r_cmd;
    logic [POS_W-1:0]  r_pos;
    logic [DATA_W-1:0] r_value;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;

    logic [IW-1:0]     r_rptr;
    logic [IW-1:0]     r_waddr;
    logic [CW-1:0]     r_left;
    logic              r_pend;
    logic              r_up;

    logic [CMPW-1:0]   pos_ext;
    logic [CMPW-1:0]   cnt_ext;
    logic [CMPW-1:0]   eff_pos;
    logic [IW-1:0]     eff_idx;
    logic [CW-1:0]     eff_cnt;
    logic [CW-1:0]     cnt_m1;
    logic              empty;
    logic              full;
    logic              do_read;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [IW-1:0]     mem_raddr;
    t_dp_stat          stat;

    assign pos_ext = CMPW'(r_pos);
    assign cnt_ext = CMPW'(r_count);
    assign empty   = (r_count == '0);
    assign full    = (r_count == CW'(CAPACITY));
    assign cnt_m1  = r_count - CW'(1);

    // decode class, target position and check result
    always_comb begin
        stat = '0;
        eff_pos = pos_ext;
        case (r_cmd)
            CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT: begin
                stat.ins = 1'b1;
                if (r_cmd == CMD_PUSH_BACK) begin
                    eff_pos = cnt_ext;
                end else if (r_cmd == CMD_PUSH_FRONT) begin
                    eff_pos = '0;
                end
                if (full) begin
                    stat.status = ST_FULL;
                end else if (eff_pos > cnt_ext) begin
                    stat.status = ST_BADIDX;
                end else begin
                    stat.status = ST_OK;
                end
            end
            CMD_POP_FRONT, CMD_REMOVE: begin
                stat.rem = 1'b1;
                if (r_cmd == CMD_POP_FRONT) begin
                    eff_pos = '0;
                end
                if (empty) begin
                    stat.status = ST_EMPTY;
                end else if (eff_pos >= cnt_ext) begin
                    stat.status = ST_BADIDX;
                end else begin
                    stat.status = ST_OK;
                end
            end
            CMD_POP_BACK: begin
                stat.pop_back = 1'b1;
                stat.status = empty ? ST_EMPTY : ST_OK;
            end
            CMD_READ, CMD_WRITE: begin
                stat.rd = (r_cmd == CMD_READ);
                stat.wr = (r_cmd == CMD_WRITE);
                if (empty) begin
                    stat.status = ST_EMPTY;
                end else if (eff_pos >= cnt_ext) begin
                    stat.status = ST_BADIDX;
                end else begin
                    stat.status = ST_OK;
                end
            end
            default: begin
                stat.status = ST_OK;
            end
        endcase
        stat.shift_done = (r_left == '0) && !r_pend;
    end

    assign o_stat  = stat;
    assign eff_idx = eff_pos[IW-1:0];
    assign eff_cnt = eff_pos[CW-1:0];
    assign do_read = i_cmd.step && (r_left != '0);

    // memory port selection: pending shift write or placement of the new word
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_waddr;
        mem_wdata = r_rdata;
        if (r_pend) begin
            mem_we = 1'b1;
        end else if (i_cmd.place) begin
            mem_we    = 1'b1;
            mem_waddr = eff_idx;
            mem_wdata = r_value;
        end
        mem_re    = do_read || i_cmd.read_pos;
        mem_raddr = i_cmd.read_pos ? eff_idx : r_rptr;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // command capture and shift bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_command;
            r_pos   <= i_position;
            r_value <= i_value;
        end
        if (i_cmd.setup) begin
            r_up <= stat.ins;
            if (stat.ins) begin
                r_rptr <= cnt_m1[IW-1:0];
            end else begin
                r_rptr <= eff_idx + IW'(1);
            end
        end else if (do_read) begin
            r_waddr <= r_up ? (r_rptr + IW'(1)) : (r_rptr - IW'(1));
            r_rptr  <= r_up ? (r_rptr - IW'(1)) : (r_rptr + IW'(1));
        end
    end

    always_comb begin
        n_count = r_count;
        if (stat.status == ST_OK) begin
            if (stat.ins) begin
                n_count = r_count + CW'(1);
            end else if (stat.rem || stat.pop_back) begin
                n_count = cnt_m1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_left  <= '0;
            r_pend  <= 1'b0;
        end else begin
            if (i_cmd.setup) begin
                r_left <= stat.ins ? (r_count - eff_cnt) : (cnt_m1 - eff_cnt);
                r_pend <= 1'b0;
            end else if (i_cmd.step) begin
                r_pend <= do_read;
                if (do_read) begin
                    r_left <= r_left - CW'(1);
                end
            end
            if (i_cmd.commit) begin
                r_count <= n_count;
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_read_data <= (stat.rd && stat.status == ST_OK) ? r_rdata : '0;
            o_count     <= POS_W'(n_count);
            o_is_empty  <= (n_count == '0);
            o_status    <= stat.status;
        end
    end

endmodule

`default_nettype wire

// ===== design/ial_ctrl.sv =====
// list controller: sequences check, shift, placement and result
`default_nettype none

module ial_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    output logic                   o_valid,
    output ial_pkg::t_dp_cmd       o_cmd,
    input  wire ial_pkg::t_dp_stat i_stat
);
    import ial_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CHECK  = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;
    localparam logic [1:0] S_REPORT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_valid;
    t_dp_cmd    cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    cmd.load = 1'b1;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_REPORT;
                if (i_stat.status == ST_OK) begin
                    if (i_stat.ins || i_stat.rem) begin
                        cmd.setup = 1'b1;
                        n_state   = S_SHIFT;
                    end else if (i_stat.rd) begin
                        cmd.read_pos = 1'b1;
                    end else if (i_stat.wr) begin
                        cmd.place = 1'b1;
                    end
                end
            end
            S_SHIFT: begin
                cmd.step = 1'b1;
                if (i_stat.shift_done) begin
                    cmd.place = i_stat.ins;
                    n_state   = S_REPORT;
                end
            end
            S_REPORT: begin
                cmd.commit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_REPORT);
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_cmd   = cmd;

endmodule

`default_nettype wire

// ===== design/indexed_array_list_top.sv =====
// top level of the indexed array list: controller plus datapath
//
// channel   direction  handshake               payload
// command   in         start high, busy low    i_command, i_position, i_value
// result    out        o_valid, one cycle      o_read_data, o_count, o_is_empty, o_status
//
// read, write, pop_back and any rejected command go from the check state
// straight to the report state, and the result strobe is registered after
// it; an insert-class or remove-class command passes through the shift state
// first, which it leaves once every entry to be moved has been written.
// the shift rate is set by the entry memory: one read and one write port,
// with the read data registered, so one entry moves per cycle.
// reset is synchronous and clears the count; memory contents are not cleared.
// the receiver cannot stall: each result is shown for exactly one cycle,
// and busy drops in that same cycle so the next command may be transferred.
`default_nettype none

module indexed_array_list_top #(
    parameter int CAPACITY = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [ial_pkg::CMD_W-1:0]          i_command,
    input  wire logic [ial_pkg::POS_W-1:0]          i_position,
    input  wire logic signed [ial_pkg::DATA_W-1:0]  i_value,
    output logic                                    o_valid,
    output logic signed [ial_pkg::DATA_W-1:0]       o_read_data,
    output logic [ial_pkg::POS_W-1:0]               o_count,
    output logic                                    o_is_empty,
    output logic [ial_pkg::STAT_W-1:0]              o_status
);
    import ial_pkg::*;

    t_dp_cmd  dp_cmd;   // controller to datapath commands
    t_dp_stat dp_stat;  // check result and shift progress

    ial_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (dp_cmd),
        .i_stat  (dp_stat)
    );

    // the word goes into the memory as raw bits; sign only matters at the ports
    ial_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_command   (i_command),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_read_data (o_read_data),
        .o_count     (o_count),
        .o_is_empty  (o_is_empty),
        .o_status    (o_status)
    );

endmodule

`default_nettype wire

// ===== design/ial_checker.sv =====
// port-level checks for the indexed array list, bound to the top level
`default_nettype none

module ial_checker #(
    parameter int CAPACITY = 16
) (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic                              o_valid,
    input wire logic [ial_pkg::DATA_W-1:0]        o_read_data,
    input wire logic [ial_pkg::POS_W-1:0]         o_count,
    input wire logic                              o_is_empty,
    input wire logic [ial_pkg::STAT_W-1:0]        o_status
);
    import ial_pkg::*;

    // a transferred command keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("command transfer not followed by busy");

    // the result strobe lasts one cycle
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_count == '0)))
        else $error("empty flag disagrees with count");

    // a rejected push only happens at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL) |-> (o_count == POS_W'(CAPACITY)))
        else $error("full status with count below capacity");

    // nonzero read data only with an ok status
    a_read_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_read_data != '0) |-> (o_status == ST_OK))
        else $error("read data returned with an error status");

endmodule

bind indexed_array_list_top ial_checker #(
    .CAPACITY (CAPACITY)
) u_ial_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_read_data (o_read_data),
    .o_count     (o_count),
    .o_is_empty  (o_is_empty),
    .o_status    (o_status)
);

`default_nettype wire
